// ===== rtl/core/rrd_pkg.sv =====
// Package for the read reply deframer: length limits, phase, status and kind codes,
// character constants and the hex digit decoder. No dependencies.
package rrd_pkg;

    localparam int MAX_READ_BYTES_DEF = 1024;
    localparam int LEN_W = 11;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DATA     = 3'd1;
    localparam logic [2:0] PH_DRAIN    = 3'd2;
    localparam logic [2:0] PH_CSUM     = 3'd3;
    localparam logic [2:0] PH_TAIL     = 3'd4;
    localparam logic [2:0] PH_NODOLLAR = 3'd5;
    localparam logic [2:0] PH_ERRBODY  = 3'd6;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FORMAT = 3'd1;
    localparam logic [2:0] ST_SERVER = 3'd2;
    localparam logic [2:0] ST_RLE    = 3'd3;
    localparam logic [2:0] ST_CSUM   = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_E      = 8'h45;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.nib = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.nib = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== rtl/core/rsp_read_reply_deframer.sv =====
// Read reply deframer top level: input register, per-character frame logic,
// result register. Depends on rrd_pkg.
//
// Usage:
//   s_* carries one reply character per beat in s_tdata. cfg_wr_en/cfg_wr_data
//   set the expected byte count (0 counts as 1, values above MAX_READ_BYTES
//   count as MAX_READ_BYTES); write it only while the block is idle.
//   m_* carries results: m_tuser low gives a decoded byte, m_tuser high gives
//   the final status of the frame, with m_tlast high. m_tdata holds
//   data_byte [7:0], status [10:8], server_code [18:11], zeros above.
//   Bytes leave before the checksum is known; drop them unless status is ok.
//   Each character passes from the input register through the frame logic,
//   and any result that it gives is held in the result register.
//   Throughput: one character per cycle while no result is stalled, set by
//   the combinational update of the frame state between the two registers.
//   Reset clears the frame state to waiting for '$' and empties both
//   registers; the length register returns to 1.
//   When the receiver stalls with a result pending, the held character waits
//   in the input register and s_tready drops until the result is taken.
module rsp_read_reply_deframer
    import rrd_pkg::*;
#(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,    // expected_length
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,        // rx_char
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,        // data_byte, status, server_code, zero pad
    output logic             m_tuser,        // kind
    output logic             m_tlast         // last
);

    localparam int CNT_W = $clog2(2 * MAX_READ_BYTES + 1);

    logic [LEN_W-1:0] expected_length_reg;

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       hi_reg, hi_next;
    logic [2:0]       pend_reg, pend_next;
    logic [7:0]       code_reg, code_next;
    logic [3:0]       csum_hi_reg, csum_hi_next;
    logic             badhex_reg, badhex_next;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic [2:0]       out_status_reg;
    logic [7:0]       out_code_reg;

    logic             emit;
    logic             emit_kind;
    logic [7:0]       emit_byte;
    logic [2:0]       emit_status;
    logic [7:0]       emit_code;

    logic             advance;
    logic [CNT_W-2:0] len_c;
    logic [CNT_W-1:0] target;
    logic [7:0]       c;
    hex_t             h;
    logic [2:0]       pend_tmp;
    logic [7:0]       got;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_kind_reg;
    assign m_tdata  = {5'd0, out_code_reg, out_status_reg, out_byte_reg};

    always_comb
    begin
        if (expected_length_reg == '0)
        begin
            len_c = (CNT_W-1)'(1);
        end
        else if (32'(expected_length_reg) > MAX_READ_BYTES)
        begin
            len_c = (CNT_W-1)'(MAX_READ_BYTES);
        end
        else
        begin
            len_c = (CNT_W-1)'(expected_length_reg);
        end
        target = {len_c, 1'b0};
    end

    always_comb
    begin
        c            = in_char_reg;
        h            = hex_decode(in_char_reg);
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        hi_next      = hi_reg;
        pend_next    = pend_reg;
        code_next    = code_reg;
        csum_hi_next = csum_hi_reg;
        badhex_next  = badhex_reg;
        emit         = 1'b0;
        emit_kind    = KIND_DATA;
        emit_byte    = 8'd0;
        emit_status  = ST_OK;
        emit_code    = 8'd0;
        pend_tmp     = pend_reg;
        got          = {csum_hi_reg, h.nib};

        case (phase_reg)
            PH_IDLE:
            begin
                sum_next     = 8'd0;
                cnt_next     = '0;
                hi_next      = 4'd0;
                code_next    = 8'd0;
                csum_hi_next = 4'd0;
                badhex_next  = 1'b0;
                if (c == CH_DOLLAR)
                begin
                    pend_next  = ST_OK;
                    phase_next = PH_DATA;
                end
                else
                begin
                    pend_next  = ST_FORMAT;
                    phase_next = (c == CH_HASH) ? PH_TAIL : PH_NODOLLAR;
                end
            end
            PH_DATA:
            begin
                if (c == CH_HASH)
                begin
                    if (cnt_reg != target && pend_reg != ST_RLE)
                    begin
                        pend_next = ST_FORMAT;
                    end
                    cnt_next   = '0;
                    phase_next = PH_CSUM;
                end
                else if (cnt_reg == '0 && c == CH_E)
                begin
                    pend_next   = ST_SERVER;
                    code_next   = 8'd0;
                    badhex_next = 1'b0;
                    phase_next  = PH_ERRBODY;
                end
                else if (cnt_reg >= target)
                begin
                    if (c == CH_STAR)
                    begin
                        pend_next = ST_RLE;
                    end
                    else if (pend_reg != ST_RLE)
                    begin
                        pend_next = ST_FORMAT;
                    end
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    if (c == CH_STAR)
                    begin
                        pend_next = ST_RLE;
                    end
                    sum_next = sum_reg + c;
                    if (!h.ok)
                    begin
                        badhex_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (!cnt_reg[0])
                    begin
                        hi_next = h.nib;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_DATA;
                        emit_byte = {hi_reg, h.nib};
                    end
                end
            end
            PH_DRAIN:
            begin
                if (c == CH_STAR)
                begin
                    pend_next = ST_RLE;
                end
                if (c == CH_HASH)
                begin
                    cnt_next   = '0;
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                if (c == CH_STAR)
                begin
                    pend_tmp = ST_RLE;
                end
                else if (!h.ok && pend_reg == ST_OK)
                begin
                    pend_tmp = ST_CSUM;
                end
                pend_next = pend_tmp;
                if (cnt_reg == '0)
                begin
                    csum_hi_next = h.nib;
                    cnt_next     = CNT_W'(1);
                end
                else
                begin
                    if (pend_tmp == ST_OK)
                    begin
                        if (got != sum_reg)
                        begin
                            pend_tmp = ST_CSUM;
                        end
                        else if (badhex_reg)
                        begin
                            pend_tmp = ST_FORMAT;
                        end
                    end
                    pend_next   = pend_tmp;
                    emit        = 1'b1;
                    emit_kind   = KIND_STATUS;
                    emit_status = pend_tmp;
                    emit_code   = 8'd0;
                    phase_next  = PH_IDLE;
                end
            end
            PH_ERRBODY:
            begin
                if (c == CH_HASH)
                begin
                    if (cnt_reg != CNT_W'(2) || badhex_reg)
                    begin
                        code_next = 8'd0;
                    end
                    cnt_next   = '0;
                    phase_next = PH_TAIL;
                end
                else
                begin
                    if (!h.ok || cnt_reg >= CNT_W'(2))
                    begin
                        badhex_next = 1'b1;
                    end
                    else if (cnt_reg == '0)
                    begin
                        hi_next = h.nib;
                    end
                    else
                    begin
                        code_next = {hi_reg, h.nib};
                    end
                    if (cnt_reg < CNT_W'(2))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            PH_NODOLLAR:
            begin
                if (c == CH_HASH)
                begin
                    cnt_next   = '0;
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next = CNT_W'(1);
                end
                else
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_STATUS;
                    emit_status = pend_reg;
                    emit_code   = (pend_reg == ST_SERVER) ? code_reg : 8'd0;
                    phase_next  = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_length_reg <= LEN_W'(1);
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            out_kind_reg        <= KIND_DATA;
            phase_reg           <= PH_IDLE;
            sum_reg             <= 8'd0;
            cnt_reg             <= '0;
            hi_reg              <= 4'd0;
            pend_reg            <= ST_OK;
            code_reg            <= 8'd0;
            csum_hi_reg         <= 4'd0;
            badhex_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                expected_length_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= emit;
                out_kind_reg  <= emit_kind;
                phase_reg     <= phase_next;
                sum_reg       <= sum_next;
                cnt_reg       <= cnt_next;
                hi_reg        <= hi_next;
                pend_reg      <= pend_next;
                code_reg      <= code_next;
                csum_hi_reg   <= csum_hi_next;
                badhex_reg    <= badhex_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
        if (advance)
        begin
            out_byte_reg   <= emit_byte;
            out_status_reg <= emit_status;
            out_code_reg   <= emit_code;
        end
    end

endmodule

// ===== rtl/core/rrd_checker.sv =====
// Port checker for the read reply deframer, bound to the top level.
// Depends on rrd_pkg and rsp_read_reply_deframer.
module rrd_checker
    import rrd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("tlast does not match status beat");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DATA) |-> (m_tdata[23:8] == 16'd0))
        else $error("data beat carries status bits");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_STATUS) |->
            (m_tdata[7:0] == 8'd0) && (m_tdata[23:19] == 5'd0) &&
            ((m_tdata[10:8] == ST_SERVER) || (m_tdata[18:11] == 8'd0)))
        else $error("status beat malformed");

endmodule

bind rsp_read_reply_deframer rrd_checker u_rrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/tb_rsp_read_reply_deframer.sv =====
// Testbench for rsp_read_reply_deframer: streams framed read replies, good and
// damaged, with random gaps and stalls, and checks every result beat against
// a built-in deframer. Depends on rrd_pkg and the RTL top level.
module tb_rsp_read_reply_deframer;
    import rrd_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TOTAL_CHARS   = 1750;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [7:0] server_code;
        logic       last;
    } reply_item_t;

    typedef enum logic [1:0] { DO_CHAR, DO_CONFIG, DO_DRAIN } step_op_t;

    typedef struct packed {
        step_op_t    op;
        logic [10:0] value;
    } step_t;

    typedef enum int {
        FR_OK, FR_BAD_SUM, FR_BAD_SUM_DIGIT, FR_BAD_DIGIT, FR_STAR, FR_EARLY_HASH,
        FR_EXTRA, FR_NO_DOLLAR, FR_SERVER, FR_SERVER_ODD, FR_NOISE
    } frame_kind_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    step_t       script[$];
    reply_item_t pending_results[$];

    // deframer state
    logic [10:0] len_reg = 11'd1;
    logic [2:0]  frame_phase = PH_IDLE;
    logic [7:0]  frame_sum = '0;
    int unsigned digit_count = 0;
    logic [3:0]  hi_nib = '0;
    logic [2:0]  verdict = ST_OK;
    logic [7:0]  err_code = '0;
    logic [3:0]  csum_hi = '0;
    logic        bad_digit = 1'b0;

    logic [10:0] gen_len = 11'd1;
    int          chars_queued = 0;
    int          frames_queued = 0;
    int          chars_sent = 0;
    int          configs_done = 0;
    int          pauses_done = 0;
    int          data_beats = 0;
    int          status_tally[8];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          settle_left = SETTLE_CYCLES;
    logic        send_calm = 1'b0;
    logic        take_calm = 1'b0;

    rsp_read_reply_deframer #(
        .MAX_READ_BYTES(MAX_READ_BYTES_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c) - 48;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c) - 55;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c) - 87;
        end
        return -1;
    endfunction

    function automatic int unsigned eff_len(input logic [10:0] n);
        if (n == 0)
        begin
            return 1;
        end
        if (n > MAX_READ_BYTES_DEF)
        begin
            return MAX_READ_BYTES_DEF;
        end
        return n;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        pending_results.push_back('{kind: KIND_DATA, data_byte: b, status: ST_OK,
                                    server_code: 8'h00, last: 1'b0});
    endtask

    task automatic push_status(input logic [2:0] st, input logic [7:0] code);
        pending_results.push_back('{kind: KIND_STATUS, data_byte: 8'h00, status: st,
                                    server_code: (st == ST_SERVER) ? code : 8'h00,
                                    last: 1'b1});
        frame_phase = PH_IDLE;
    endtask

    task automatic flag_format();
        if (verdict != ST_RLE)
        begin
            verdict = ST_FORMAT;
        end
    endtask

    task automatic deframe_char(input logic [7:0] c);
        int          v;
        int unsigned target;
        v = digit_value(c);
        target = 2 * eff_len(len_reg);
        case (frame_phase)
            PH_IDLE:
            begin
                frame_sum = '0;
                digit_count = 0;
                hi_nib = '0;
                err_code = '0;
                csum_hi = '0;
                bad_digit = 1'b0;
                if (c == CH_DOLLAR)
                begin
                    verdict = ST_OK;
                    frame_phase = PH_DATA;
                end
                else
                begin
                    verdict = ST_FORMAT;
                    frame_phase = (c == CH_HASH) ? PH_TAIL : PH_NODOLLAR;
                end
            end
            PH_DATA:
            begin
                if (c == CH_HASH)
                begin
                    if (digit_count != target)
                    begin
                        flag_format();
                    end
                    digit_count = 0;
                    frame_phase = PH_CSUM;
                end
                else if (digit_count == 0 && c == CH_E)
                begin
                    verdict = ST_SERVER;
                    err_code = '0;
                    bad_digit = 1'b0;
                    frame_phase = PH_ERRBODY;
                end
                else if (digit_count >= target)
                begin
                    if (c == CH_STAR)
                    begin
                        verdict = ST_RLE;
                    end
                    else
                    begin
                        flag_format();
                    end
                    frame_phase = PH_DRAIN;
                end
                else
                begin
                    if (c == CH_STAR)
                    begin
                        verdict = ST_RLE;
                    end
                    frame_sum = frame_sum + c;
                    if (v < 0)
                    begin
                        bad_digit = 1'b1;
                        v = 0;
                    end
                    digit_count++;
                    if (digit_count % 2 == 1)
                    begin
                        hi_nib = 4'(v);
                    end
                    else
                    begin
                        push_byte({hi_nib, 4'(v)});
                    end
                end
            end
            PH_DRAIN:
            begin
                if (c == CH_STAR)
                begin
                    verdict = ST_RLE;
                end
                if (c == CH_HASH)
                begin
                    digit_count = 0;
                    frame_phase = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                if (c == CH_STAR)
                begin
                    verdict = ST_RLE;
                end
                else if (v < 0 && verdict == ST_OK)
                begin
                    verdict = ST_CSUM;
                end
                if (digit_count == 0)
                begin
                    csum_hi = (v < 0) ? 4'h0 : 4'(v);
                    digit_count = 1;
                end
                else
                begin
                    if (verdict == ST_OK)
                    begin
                        if ({csum_hi, 4'(v)} != frame_sum)
                        begin
                            verdict = ST_CSUM;
                        end
                        else if (bad_digit)
                        begin
                            verdict = ST_FORMAT;
                        end
                    end
                    push_status(verdict, 8'h00);
                end
            end
            PH_ERRBODY:
            begin
                if (c == CH_HASH)
                begin
                    if (digit_count != 2 || bad_digit)
                    begin
                        err_code = '0;
                    end
                    digit_count = 0;
                    frame_phase = PH_TAIL;
                end
                else
                begin
                    if (v < 0 || digit_count >= 2)
                    begin
                        bad_digit = 1'b1;
                    end
                    else if (digit_count == 0)
                    begin
                        hi_nib = 4'(v);
                    end
                    else
                    begin
                        err_code = {hi_nib, 4'(v)};
                    end
                    if (digit_count < 2)
                    begin
                        digit_count++;
                    end
                end
            end
            PH_NODOLLAR:
            begin
                if (c == CH_HASH)
                begin
                    digit_count = 0;
                    frame_phase = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                if (digit_count == 0)
                begin
                    digit_count = 1;
                end
                else
                begin
                    push_status(verdict, err_code);
                end
            end
            default:
            begin
                frame_phase = PH_IDLE;
            end
        endcase
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return 8'h41 + 8'(n) - 8'd10;
        end
        return 8'h61 + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (digit_value(c) >= 0 || c == CH_HASH || c == CH_STAR);
        return c;
    endfunction

    function automatic logic [7:0] any_but_hash();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_HASH);
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 7))
            0: return CH_DOLLAR;
            1: return CH_HASH;
            2: return CH_STAR;
            3: return CH_E;
            4: return hex_digit(4'($urandom_range(0, 15)));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [10:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 11'($urandom_range(1, 6));
        end
        if (r < 75)
        begin
            return 11'd0;
        end
        if (r < 85)
        begin
            return 11'($urandom_range(7, 40));
        end
        if (r < 92)
        begin
            return 11'(MAX_READ_BYTES_DEF);
        end
        return 11'($urandom_range(MAX_READ_BYTES_DEF + 1, 2047));
    endfunction

    function automatic frame_kind_t pick_kind(input int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (n > 12)
        begin
            case (r % 5)
                0: return FR_EARLY_HASH;
                1: return FR_NO_DOLLAR;
                2: return FR_SERVER;
                3: return FR_SERVER_ODD;
                default: return FR_NOISE;
            endcase
        end
        if (r < 55)
        begin
            return FR_OK;
        end
        case (r % 10)
            0: return FR_BAD_SUM;
            1: return FR_BAD_SUM_DIGIT;
            2: return FR_BAD_DIGIT;
            3: return FR_STAR;
            4: return FR_EARLY_HASH;
            5: return FR_EXTRA;
            6: return FR_NO_DOLLAR;
            7: return FR_SERVER;
            8: return FR_SERVER_ODD;
            default: return FR_NOISE;
        endcase
    endfunction

    task automatic add_char(input logic [7:0] c);
        script.push_back('{op: DO_CHAR, value: {3'b000, c}});
        chars_queued++;
    endtask

    task automatic add_config(input logic [10:0] v);
        script.push_back('{op: DO_CONFIG, value: v});
        gen_len = v;
    endtask

    task automatic add_pause();
        script.push_back('{op: DO_DRAIN, value: 11'd0});
    endtask

    task automatic add_frame(input int unsigned n, input frame_kind_t kind, input int fill);
        logic [7:0]  body[$];
        logic [7:0]  csum[2];
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned k;
        int unsigned mode;
        frames_queued++;
        sum = '0;
        mode = $urandom_range(0, 2);
        case (kind)
            FR_NO_DOLLAR:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_DOLLAR);
                add_char(b);
                if (b != CH_HASH)
                begin
                    repeat ($urandom_range(0, 4)) add_char(any_but_hash());
                    add_char(CH_HASH);
                end
                add_char(8'($urandom_range(0, 255)));
                add_char(8'($urandom_range(0, 255)));
            end
            FR_SERVER, FR_SERVER_ODD:
            begin
                add_char(CH_DOLLAR);
                add_char(CH_E);
                if (kind == FR_SERVER)
                begin
                    add_char(hex_digit(4'($urandom_range(0, 15))));
                    add_char(hex_digit(4'($urandom_range(0, 15))));
                end
                else
                begin
                    repeat ($urandom_range(0, 4)) add_char(any_but_hash());
                end
                add_char(CH_HASH);
                add_char(8'($urandom_range(0, 255)));
                add_char(8'($urandom_range(0, 255)));
            end
            FR_NOISE:
            begin
                repeat ($urandom_range(1, 8)) add_char(noise_char());
            end
            default:
            begin
                for (int unsigned i = 0; i < n; i++)
                begin
                    b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
                    body.push_back(hex_digit(b[7:4]));
                    body.push_back(hex_digit(b[3:0]));
                end
                k = $urandom_range(0, body.size() - 1);
                if (kind == FR_BAD_DIGIT)
                begin
                    body[k] = junk_char();
                end
                if (kind == FR_STAR && mode == 0)
                begin
                    body[k] = CH_STAR;
                end
                if (kind == FR_EARLY_HASH)
                begin
                    k = $urandom_range(0, (2 * n - 1 < 9) ? 2 * n - 1 : 9);
                    while (body.size() > k)
                    begin
                        body.delete(body.size() - 1);
                    end
                end
                foreach (body[i])
                begin
                    sum = sum + body[i];
                end
                if (kind == FR_BAD_SUM)
                begin
                    sum = sum ^ 8'($urandom_range(1, 255));
                end
                csum[0] = hex_digit(sum[7:4]);
                csum[1] = hex_digit(sum[3:0]);
                if (kind == FR_BAD_SUM_DIGIT)
                begin
                    csum[$urandom_range(0, 1)] = junk_char();
                end
                if (kind == FR_STAR && mode == 1)
                begin
                    body.push_back(CH_STAR);
                end
                if (kind == FR_STAR && mode == 2)
                begin
                    csum[$urandom_range(0, 1)] = CH_STAR;
                end
                if (kind == FR_EXTRA)
                begin
                    repeat ($urandom_range(1, 4)) body.push_back(any_but_hash());
                end
                add_char(CH_DOLLAR);
                foreach (body[i])
                begin
                    add_char(body[i]);
                end
                add_char(CH_HASH);
                add_char(csum[0]);
                add_char(csum[1]);
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic       next_valid;
        logic [7:0] next_char;
        logic       next_cfg;
        step_t      head;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            cfg_wr_en <= 1'b0;
            cfg_wr_data <= '0;
            gap_left = 0;
            settle_left = SETTLE_CYCLES;
        end
        else
        begin
            next_valid = s_tvalid;
            next_char = s_tdata;
            next_cfg = 1'b0;
            if (s_tvalid && s_tready)
            begin
                deframe_char(s_tdata);
                chars_sent++;
                next_valid = 1'b0;
                settle_left = SETTLE_CYCLES;
                if ($urandom_range(0, 39) == 0)
                begin
                    send_calm = !send_calm;
                end
                gap_left = send_calm ? 0 : $urandom_range(0, 12);
            end
            if (pending_results.size() != 0)
            begin
                settle_left = SETTLE_CYCLES;
            end
            if (!next_valid && script.size() != 0)
            begin
                case (script[0].op)
                    DO_CHAR:
                    begin
                        if (gap_left != 0)
                        begin
                            gap_left--;
                        end
                        else
                        begin
                            head = script.pop_front();
                            next_valid = 1'b1;
                            next_char = head.value[7:0];
                        end
                    end
                    DO_CONFIG:
                    begin
                        // hold the write until the last beat has cleared the pipeline
                        if (settle_left != 0)
                        begin
                            settle_left--;
                        end
                        else
                        begin
                            head = script.pop_front();
                            next_cfg = 1'b1;
                            cfg_wr_data <= head.value;
                            len_reg = head.value;
                            configs_done++;
                        end
                    end
                    default:
                    begin
                        if (pending_results.size() == 0)
                        begin
                            head = script.pop_front();
                            pauses_done++;
                        end
                    end
                endcase
            end
            s_tvalid <= next_valid;
            s_tdata <= next_char;
            cfg_wr_en <= next_cfg;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_item_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fail_count < PRINT_LIMIT)
                    begin
                        $display("%0t: no beat expected, got tdata %0h tuser %0b tlast %0b",
                                 $time, m_tdata, m_tuser, m_tlast);
                    end
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.kind == KIND_STATUS)
                    begin
                        status_tally[want.status]++;
                    end
                    else
                    begin
                        data_beats++;
                    end
                    if (m_tuser !== want.kind)
                    begin
                        note_mismatch("kind", 8'(want.kind), 8'(m_tuser));
                    end
                    if (m_tdata[7:0] !== want.data_byte)
                    begin
                        note_mismatch("data_byte", want.data_byte, m_tdata[7:0]);
                    end
                    if (m_tdata[10:8] !== want.status)
                    begin
                        note_mismatch("status", 8'(want.status), 8'(m_tdata[10:8]));
                    end
                    if (m_tdata[18:11] !== want.server_code)
                    begin
                        note_mismatch("server_code", want.server_code, m_tdata[18:11]);
                    end
                    if (m_tlast !== want.last)
                    begin
                        note_mismatch("last", 8'(want.last), 8'(m_tlast));
                    end
                    if (m_tdata[23:19] !== 5'd0)
                    begin
                        note_mismatch("tdata padding", 8'h00, 8'(m_tdata[23:19]));
                    end
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    take_calm = !take_calm;
                end
                stall_left = take_calm ? 0 : $urandom_range(0, 12);
            end
            m_tready <= (stall_left == 0);
            if (stall_left != 0)
            begin
                stall_left--;
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timed out, %0d results outstanding", $time, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int frames_left;
        int unsigned n;

        // directed: byte extremes, each error class, then a drain and length zero
        add_frame(1, FR_OK, 8'hFF);
        add_frame(1, FR_BAD_SUM, 8'h00);
        add_frame(1, FR_STAR, -1);
        add_frame(1, FR_EARLY_HASH, -1);
        add_frame(1, FR_SERVER, -1);
        add_frame(1, FR_NO_DOLLAR, -1);
        add_pause();
        add_config(11'd0);
        add_frame(1, FR_BAD_DIGIT, -1);

        // the largest size and the clamp above it
        add_config(11'(MAX_READ_BYTES_DEF));
        add_frame(eff_len(gen_len), FR_SERVER, -1);
        add_config(11'h7FF);
        add_frame(eff_len(gen_len), FR_EARLY_HASH, -1);
        add_frame(eff_len(gen_len), FR_NOISE, -1);

        frames_left = 0;
        while (chars_queued < TOTAL_CHARS)
        begin
            if (frames_left == 0)
            begin
                add_config(pick_length());
                frames_left = $urandom_range(8, 30);
            end
            frames_left--;
            n = eff_len(gen_len);
            add_frame(n, pick_kind(n), -1);
            if ($urandom_range(0, 49) == 0)
            begin
                add_pause();
            end
        end

        wait (rst_n);
        while (script.size() != 0 || s_tvalid || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            fail_count++;
        end
        $display("Sent %0d characters in %0d frames over %0d length writes, %0d drain pauses.",
                 chars_sent, frames_queued, configs_done, pauses_done);
        $display("Checked %0d data beats; statuses ok %0d, format %0d, server %0d, rle %0d, sum %0d.",
                 data_beats, status_tally[ST_OK], status_tally[ST_FORMAT],
                 status_tally[ST_SERVER], status_tally[ST_RLE], status_tally[ST_CSUM]);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
